FILE: rtl/sbmq_pkg.sv
`default_nettype none

package sbmq_pkg;

    localparam int Q_ID_BITS     = 2;
    localparam int WORD_BITS     = 32;
    localparam int MAX_QUEUE_IDS = 2 ** Q_ID_BITS;

    localparam int DEF_SLOTS     = 16;
    localparam int DEF_QUEUES    = 4;
    localparam int DEF_DATA_BITS = 32;

    localparam logic [WORD_BITS-1:0] UNDERFLOW_WORD = '1;
    localparam logic [WORD_BITS-1:0] ENQ_WORD       = '0;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_op                   kind;
        logic [Q_ID_BITS-1:0]  queue_id;
        logic signed [WORD_BITS-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] data_out;
        t_status                     status;
    } t_out_item;

    typedef struct packed {
        t_op                   op;
        logic                  q_ok;
        logic [Q_ID_BITS-1:0]  queue_id;
        logic [WORD_BITS-1:0]  word;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/sbmq_front.sv
`default_nettype none

module sbmq_front #(
    parameter int QUEUES = sbmq_pkg::DEF_QUEUES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  sbmq_pkg::t_in_item  i_req,
    input  logic                i_hold,
    output logic                o_cmd_valid,
    output sbmq_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_take
);
    import sbmq_pkg::*;

    t_cmd        r_ent [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_push;
    t_cmd        w_cmd;

    always_comb begin
        w_cmd.op       = i_req.kind;
        w_cmd.q_ok     = (9'(i_req.queue_id) < 9'(QUEUES));
        w_cmd.queue_id = i_req.queue_id;
        w_cmd.word     = i_req.data_in;
    end

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_ent[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_cmd_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbmq_res_q.sv
`default_nettype none

module sbmq_res_q (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  sbmq_pkg::t_out_item i_res,
    output logic                o_room,
    output logic                o_empty,
    input  logic                i_pop,
    output sbmq_pkg::t_out_item o_res
);
    import sbmq_pkg::*;

    t_out_item   r_ent [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_pop;

    assign o_room  = (r_cnt != 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_ent[r_rd_ptr];
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_wr && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ent[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbmq_back.sv
`default_nettype none

module sbmq_back #(
    parameter int SLOTS     = sbmq_pkg::DEF_SLOTS,
    parameter int QUEUES    = sbmq_pkg::DEF_QUEUES,
    parameter int DATA_BITS = sbmq_pkg::DEF_DATA_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  sbmq_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                o_init_busy,
    input  logic                i_res_room,
    output logic                o_res_wr,
    output sbmq_pkg::t_out_item o_res
);
    import sbmq_pkg::*;

    localparam int PW   = $clog2(SLOTS + 1);
    localparam int IW   = $clog2(SLOTS);
    localparam int QTAB = (QUEUES < MAX_QUEUE_IDS) ? QUEUES : MAX_QUEUE_IDS;
    localparam int QW   = (QTAB > 1) ? $clog2(QTAB) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_init_idx;
    logic [PW-1:0]       r_head [QTAB];
    logic [PW-1:0]       r_tail [QTAB];
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [IW-1:0]       r_slot;
    logic [QW-1:0]       r_qi;
    logic                r_deq;

    logic [DATA_BITS-1:0] r_data_mem [SLOTS];
    logic [PW-1:0]        r_link_mem [SLOTS];
    logic [DATA_BITS-1:0] r_data_rd;
    logic [PW-1:0]        r_link_rd;

    logic                 w_link_we;
    logic [IW-1:0]        w_link_wa;
    logic [PW-1:0]        w_link_wd;
    logic [IW-1:0]        w_link_ra;
    logic                 w_data_we;
    logic [IW-1:0]        w_data_addr;
    logic [DATA_BITS-1:0] w_store_word;
    logic [WORD_BITS-1:0] w_load_word;

    logic                 w_go;
    logic [QW-1:0]        w_qi;
    logic [PW-1:0]        w_head_q;
    logic                 w_head_ok;
    logic                 w_free_ok;
    logic                 w_head_we;
    logic [QW-1:0]        w_head_wa;
    logic [PW-1:0]        w_head_wd;
    logic                 w_tail_we;
    logic                 w_start;

    generate
        if (DATA_BITS > WORD_BITS) begin : g_wide
            assign w_store_word = {{(DATA_BITS - WORD_BITS){1'b0}}, i_cmd.word};
            assign w_load_word  = r_data_rd[WORD_BITS-1:0];
        end else if (DATA_BITS == WORD_BITS) begin : g_same
            assign w_store_word = i_cmd.word;
            assign w_load_word  = r_data_rd;
        end else begin : g_narrow
            assign w_store_word = i_cmd.word[DATA_BITS-1:0];
            assign w_load_word  = {{(WORD_BITS - DATA_BITS){r_data_rd[DATA_BITS-1]}},
                                   r_data_rd};
        end
    endgenerate

    assign w_go      = (r_state == S_EXEC) && i_cmd_valid && i_res_room;
    assign w_qi      = i_cmd.queue_id[QW-1:0];
    assign w_head_q  = r_head[w_qi];
    assign w_head_ok = i_cmd.q_ok && (w_head_q < NIL);
    assign w_free_ok = (r_free_head < NIL);
    assign o_init_busy = (r_state == S_INIT);

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        o_cmd_take   = 1'b0;
        o_res_wr     = 1'b0;
        o_res.data_out = ENQ_WORD;
        o_res.status   = ST_OK;
        w_link_we    = 1'b0;
        w_link_wa    = r_slot;
        w_link_wd    = NIL;
        w_link_ra    = r_free_head[IW-1:0];
        w_data_we    = 1'b0;
        w_data_addr  = r_free_head[IW-1:0];
        w_head_we    = 1'b0;
        w_head_wa    = w_qi;
        w_head_wd    = r_free_head;
        w_tail_we    = 1'b0;
        w_start      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                w_link_we = 1'b1;
                w_link_wa = r_init_idx;
                w_link_wd = PW'(r_init_idx) + PW'(1);
                if (r_init_idx == LAST_SLOT) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.op == OP_ENQ) begin
                        if (!i_cmd.q_ok || !w_free_ok) begin
                            o_res_wr     = 1'b1;
                            o_res.status = ST_OVERFLOW;
                        end else begin
                            w_start   = 1'b1;
                            w_data_we = 1'b1;
                            w_tail_we = 1'b1;
                            if (w_head_ok) begin
                                w_link_we = 1'b1;
                                w_link_wa = r_tail[w_qi][IW-1:0];
                                w_link_wd = r_free_head;
                            end else begin
                                w_head_we = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                    end else begin
                        if (!w_head_ok) begin
                            o_res_wr       = 1'b1;
                            o_res.data_out = UNDERFLOW_WORD;
                            o_res.status   = ST_UNDERFLOW;
                        end else begin
                            w_start     = 1'b1;
                            w_link_ra   = w_head_q[IW-1:0];
                            w_data_addr = w_head_q[IW-1:0];
                            n_state     = S_FIN;
                        end
                    end
                end
            end
            S_FIN: begin
                o_res_wr  = 1'b1;
                w_link_we = 1'b1;
                w_link_wa = r_slot;
                if (r_deq) begin
                    w_link_wd      = r_free_head;
                    n_free_head    = PW'(r_slot);
                    w_head_we      = 1'b1;
                    w_head_wa      = r_qi;
                    w_head_wd      = r_link_rd;
                    o_res.data_out = w_load_word;
                end else begin
                    w_link_wd   = NIL;
                    n_free_head = r_link_rd;
                end
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_wa] <= w_link_wd;
        end
        r_link_rd <= r_link_mem[w_link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            r_data_mem[w_data_addr] <= w_store_word;
        end
        r_data_rd <= r_data_mem[w_data_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_deq  <= (i_cmd.op == OP_DEQ);
            r_qi   <= w_qi;
            r_slot <= (i_cmd.op == OP_DEQ) ? w_head_q[IW-1:0] : r_free_head[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_free_head <= '0;
            for (int i = 0; i < QTAB; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            if (r_state == S_INIT) begin
                r_init_idx <= r_init_idx + IW'(1);
            end
            if (w_head_we) begin
                r_head[w_head_wa] <= w_head_wd;
            end
            if (w_tail_we) begin
                r_tail[w_qi] <= r_free_head;
            end
        end
    end

    a_fin_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> o_res_wr)
        else $error("An operation finished without a result beat.");

    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (!o_cmd_take && !o_res_wr))
        else $error("Work was done during the link initialization sweep.");

    a_res_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_wr |-> i_res_room)
        else $error("A result beat was written into a full result queue.");

    a_start_goes_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_take && !o_res_wr) |=> (r_state == S_FIN))
        else $error("An accepted operation did not reach its second cycle.");

    a_free_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_free_head <= NIL))
        else $error("The free list head holds an out of range code.");

endmodule

`default_nettype wire

FILE: rtl/shared_buffer_multi_queue_top.sv
`default_nettype none

// Port      Dir  Handshake          Beat contents
// i_req     in   push / full        kind, queue_id, data_in
// o_rsp     out  empty / pop        data_out, status
//
// A successful enqueue or dequeue first reads the link memory in S_EXEC of the
// execution unit, then writes the free list and the link in S_FIN.
// An overflow or underflow answer is written directly from S_EXEC.
// After reset the link memory is initialized by a sweep over all slots, and full stays
// high until that sweep is done.
// Two-entry queues at the input and at the output let either side stall alone.

module shared_buffer_multi_queue_top #(
    parameter int SLOTS     = sbmq_pkg::DEF_SLOTS,
    parameter int QUEUES    = sbmq_pkg::DEF_QUEUES,
    parameter int DATA_BITS = sbmq_pkg::DEF_DATA_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  sbmq_pkg::t_in_item  i_req,
    output logic                empty,
    input  logic                pop,
    output sbmq_pkg::t_out_item o_rsp
);
    import sbmq_pkg::*;

    logic      w_cmd_valid;
    t_cmd      w_cmd;
    logic      w_cmd_take;
    logic      w_init_busy;
    logic      w_res_room;
    logic      w_res_wr;
    t_out_item w_res;

    sbmq_front #(
        .QUEUES (QUEUES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req       (i_req),
        .i_hold      (w_init_busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    sbmq_back #(
        .SLOTS     (SLOTS),
        .QUEUES    (QUEUES),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_init_busy (w_init_busy),
        .i_res_room  (w_res_room),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res)
    );

    sbmq_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_res   (w_res),
        .o_room  (w_res_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_rsp)
    );

endmodule

`default_nettype wire
